[rtl/ebf_pkg.sv]
// Shared types and constants for the EDID base block filter.
`default_nettype none

package ebf_pkg;

   localparam int POS_W = 7;

   localparam logic [POS_W-1:0] POS_INPUT_DEF = 7'd20;
   localparam logic [POS_W-1:0] POS_FEATURES  = 7'd24;
   localparam logic [POS_W-1:0] POS_CHECKSUM  = 7'd127;
   localparam int DESC_BASE   = 54;
   localparam int DESC_STRIDE = 18;

   localparam logic [7:0] ANALOG_FLAG   = 8'h80;
   localparam logic [7:0] COLOR_MASK    = 8'hE7;
   localparam logic [7:0] COLOR_ANALOG  = 8'h08;
   localparam logic [7:0] FEATURE_MASK  = 8'h1F;

   localparam logic [15:0] MAX_PIXEL_CLOCK_RESET = 16'd16000;

   localparam logic CSR_ANALOG_MODE     = 1'b0;
   localparam logic CSR_MAX_PIXEL_CLOCK = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = 2;
   localparam int CNT_W       = 3;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_ANALOG  = 2'd1,
      ACT_DIGITAL = 2'd2
   } action_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       block_end;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type w0;
      rsp_word_type w1;
   } push_type;

endpackage

`default_nettype wire

[rtl/ebf_core.sv]
// Byte rewrite logic: position tracking, field edits and checksum correction.
`default_nettype none

module ebf_core
   import ebf_pkg::*;
#(
   parameter int NUM_DESCRIPTORS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        fire,
   input  wire logic [7:0]  in_byte,
   input  wire logic        analog_mode,
   input  wire logic [15:0] max_pixel_clock,
   output push_type         push
);

   logic [POS_W-1:0] pos_ff, pos_in;
   action_type       action_ff, action_in;
   logic [7:0]       held_ff, held_in;
   logic [7:0]       delta_ff, delta_in;
   logic             lo_hit, hi_hit;
   logic [15:0]      clk_val;
   logic [7:0]       v;

   always_comb begin
      lo_hit = 1'b0;
      hi_hit = 1'b0;
      for (int i = 0; i < NUM_DESCRIPTORS; i++) begin
         if (pos_ff == POS_W'(DESC_BASE + DESC_STRIDE * i)) begin
            lo_hit = 1'b1;
         end
         if (pos_ff == POS_W'(DESC_BASE + DESC_STRIDE * i + 1)) begin
            hi_hit = 1'b1;
         end
      end
   end

   assign clk_val = {in_byte, held_ff};

   always_comb begin
      pos_in    = pos_ff + 1'b1;
      action_in = action_ff;
      held_in   = held_ff;
      delta_in  = delta_ff;
      v         = in_byte;
      push      = '0;
      push.count       = 2'd1;
      push.w0.out_byte = in_byte;
      push.w0.run_last = 1'b1;
      if (pos_ff == POS_CHECKSUM) begin
         push.w0.out_byte  = in_byte + delta_ff;
         push.w0.block_end = 1'b1;
         action_in = ACT_NONE;
         delta_in  = '0;
         held_in   = '0;
      end else if (lo_hit) begin
         held_in    = in_byte;
         push.count = 2'd0;
      end else if (hi_hit) begin
         push.count       = 2'd2;
         push.w0.out_byte = held_ff;
         push.w0.run_last = 1'b0;
         push.w1.out_byte = in_byte;
         push.w1.run_last = 1'b1;
         if (clk_val > max_pixel_clock) begin
            push.w0.out_byte = max_pixel_clock[7:0];
            push.w1.out_byte = max_pixel_clock[15:8];
            delta_in = delta_ff + held_ff - max_pixel_clock[7:0]
                       + in_byte - max_pixel_clock[15:8];
         end
      end else if (pos_ff == POS_INPUT_DEF) begin
         if (analog_mode && in_byte[7]) begin
            v         = 8'h00;
            action_in = ACT_ANALOG;
         end else if (!analog_mode && !in_byte[7]) begin
            v         = ANALOG_FLAG;
            action_in = ACT_DIGITAL;
         end else begin
            action_in = ACT_NONE;
         end
         push.w0.out_byte = v;
         delta_in = delta_ff + in_byte - v;
      end else if (pos_ff == POS_FEATURES) begin
         case (action_ff)
            ACT_ANALOG:  v = (in_byte & COLOR_MASK) | COLOR_ANALOG;
            ACT_DIGITAL: v = in_byte & COLOR_MASK;
            default:     v = in_byte;
         endcase
         v = v & FEATURE_MASK;
         push.w0.out_byte = v;
         delta_in = delta_ff + in_byte - v;
      end
      if (!fire) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         action_ff <= ACT_NONE;
         held_ff   <= '0;
         delta_ff  <= '0;
      end else if (fire) begin
         pos_ff    <= pos_in;
         action_ff <= action_in;
         held_ff   <= held_in;
         delta_ff  <= delta_in;
      end
   end

   a_block_wrap: assert property (@(posedge clock) disable iff (reset)
      (fire && pos_ff == POS_CHECKSUM) |=> (pos_ff == '0 && delta_ff == '0))
      else $error("block end did not restart position and delta");

   a_low_held: assert property (@(posedge clock) disable iff (reset)
      (fire && lo_hit && pos_ff != POS_CHECKSUM) |-> (push.count == 2'd0))
      else $error("pixel clock low byte emitted early");

endmodule

`default_nettype wire

[rtl/ebf_outq.sv]
// Result queue: takes up to two words per cycle, hands out one per cycle while rsp_ready is high.
`default_nettype none

module ebf_outq
   import ebf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  push_type         push,
   output logic             room2,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_word_type     rsp_word
);

   rsp_word_type     mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign room2     = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign rsp_word  = mem[rd_ptr_ff];
   assign wr_next   = wr_ptr_ff + 1'b1;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.w0;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.w1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (count_ff + CNT_W'(push.count) <= CNT_W'(QUEUE_DEPTH)))
      else $error("result queue overflow");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != CNT_W'(QUEUE_DEPTH)) |-> (count_ff[PTR_W-1:0] == wr_ptr_ff - rd_ptr_ff))
      else $error("queue count and pointers disagree");

endmodule

`default_nettype wire

[rtl/edid_block_filter_top.sv]
// Top level of the EDID base block filter: input register, rewrite core, result queue.
// Path: an accepted word waits in the input register and is then written to the queue,
// which offers it on rsp_. Throughput: one input word per cycle while the queue has
// room for two words; a pixel clock high byte yields two result words, its low byte
// none, so the result side also averages one word per cycle.
// Reset: clears position, action, delta, queue and the input valid flag;
// the CSRs return to analog_mode 0 and max_pixel_clock 16000.
`default_nettype none

module edid_block_filter_top
   import ebf_pkg::*;
#(
   parameter int NUM_DESCRIPTORS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   output logic             rsp_block_end,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         analog_mode_ff;
   logic [15:0]  max_clk_ff;
   logic         room2, fire;
   push_type     push;
   rsp_word_type rsp_word;

   assign fire        = in_valid_ff && room2;
   assign req_ready   = !in_valid_ff || fire;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         analog_mode_ff <= 1'b0;
         max_clk_ff     <= MAX_PIXEL_CLOCK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ANALOG_MODE:     analog_mode_ff <= csr_data[0];
            CSR_MAX_PIXEL_CLOCK: max_clk_ff     <= csr_data;
            default:             max_clk_ff     <= max_clk_ff;
         endcase
      end
   end

   ebf_core #(
      .NUM_DESCRIPTORS(NUM_DESCRIPTORS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .in_byte         (in_byte_ff),
      .analog_mode     (analog_mode_ff),
      .max_pixel_clock (max_clk_ff),
      .push            (push)
   );

   ebf_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room2     (room2),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_out_byte  = rsp_word.out_byte;
   assign rsp_run_last  = rsp_word.run_last;
   assign rsp_block_end = rsp_word.block_end;

endmodule

`default_nettype wire
